>>> rtl/cpaf_pkg.sv
`timescale 1ns / 1ps
package cpaf_pkg;

    localparam int PORT_ENTRIES_DEF = 16;
    localparam int V4_RULES_DEF     = 16;
    localparam int V6_RULES_DEF     = 16;
    localparam int IDX_W            = 4;
    localparam int V4_MAX_PREFIX    = 32;
    localparam int V6_MAX_PREFIX    = 128;
    localparam int QUEUE_DEPTH      = 2;

    typedef enum logic [2:0] {
        ACT_CHECK    = 3'd0,
        ACT_WR_PORT  = 3'd1,
        ACT_WR_V4    = 3'd2,
        ACT_WR_V6    = 3'd3,
        ACT_CLEAR    = 3'd4
    } t_action;

    typedef enum logic [3:0] {
        ST_ALLOWED       = 4'd0,
        ST_LOOPBACK      = 4'd1,
        ST_NOT_LITERAL   = 4'd2,
        ST_V6_DENIED     = 4'd3,
        ST_NO_PORTS      = 4'd4,
        ST_PORT_UNLISTED = 4'd5,
        ST_NO_V4         = 4'd6,
        ST_NO_V6         = 4'd7,
        ST_NO_MATCH      = 4'd8,
        ST_WRITE_OK      = 4'd9,
        ST_WRITE_REJECT  = 4'd10
    } t_status;

    typedef enum logic [1:0] {
        KIND_V4  = 2'd0,
        KIND_V6  = 2'd1
    } t_kind;

    typedef enum logic [2:0] {
        OP_DONE,
        OP_WR_PORT,
        OP_WR_V4,
        OP_WR_V6,
        OP_CLEAR,
        OP_CHECK_V4,
        OP_CHECK_V6
    } t_op;

    localparam logic [0:0] REG_LISTENER = 1'b0;
    localparam logic [0:0] REG_IPV6_EN  = 1'b1;

    // classified request handed from front to back
    typedef struct packed {
        t_op         op;
        t_status     status;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [15:0] port;
        logic [IDX_W-1:0] index;
        logic [7:0]  prefix;
    } t_req;

    function automatic logic [63:0] mask64(input logic [7:0] len);
        logic [63:0] m;
        m = '0;
        for (int i = 0; i < 64; i++) begin
            if (32'(len) > i) m[63-i] = 1'b1;
        end
        return m;
    endfunction

endpackage

>>> rtl/cpaf_front.sv
`timescale 1ns / 1ps
module cpaf_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [2:0]            i_action,
    input  logic [1:0]            i_address_kind,
    input  logic [63:0]           i_address_high,
    input  logic [63:0]           i_address_low,
    input  logic [15:0]           i_port_number,
    input  logic [3:0]            i_entry_index,
    input  logic [7:0]            i_prefix_length,
    input  logic [15:0]           i_listener_port,
    input  logic                  i_ipv6_enable,
    output logic                  o_q_valid,
    input  logic                  i_q_ready,
    output cpaf_pkg::t_req        o_q_req
);
    import cpaf_pkg::*;

    localparam int QW = $clog2(QUEUE_DEPTH + 1);

    t_req          r_q [QUEUE_DEPTH];
    logic [QW-1:0] r_count;
    logic          r_wp, r_rp;
    t_req          n_req;
    logic          push, pop;

    always_comb begin
        n_req.addr_high = i_address_high;
        n_req.addr_low  = i_address_low;
        n_req.port      = i_port_number;
        n_req.index     = i_entry_index;
        n_req.prefix    = i_prefix_length;
        n_req.op        = OP_DONE;
        n_req.status    = ST_WRITE_REJECT;
        case (i_action)
            ACT_CHECK: begin
                if (i_listener_port != 16'd0 && i_port_number == i_listener_port)
                    n_req.status = ST_LOOPBACK;
                else if (i_address_kind != KIND_V4 && i_address_kind != KIND_V6)
                    n_req.status = ST_NOT_LITERAL;
                else if (i_address_kind == KIND_V6 && !i_ipv6_enable)
                    n_req.status = ST_V6_DENIED;
                else
                    n_req.op = (i_address_kind == KIND_V6) ? OP_CHECK_V6 : OP_CHECK_V4;
            end
            ACT_WR_PORT: if (i_port_number != 16'd0) n_req.op = OP_WR_PORT;
            ACT_WR_V4: if (i_prefix_length <= 8'(V4_MAX_PREFIX)) n_req.op = OP_WR_V4;
            ACT_WR_V6: begin
                if (i_ipv6_enable && i_prefix_length <= 8'(V6_MAX_PREFIX))
                    n_req.op = OP_WR_V6;
            end
            ACT_CLEAR: n_req.op = OP_CLEAR;
            default: ;
        endcase
    end

    assign o_ready   = (r_count != QW'(QUEUE_DEPTH));
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_count != '0);
    assign pop       = o_q_valid && i_q_ready;
    assign o_q_req   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_count <= r_count + QW'(push) - QW'(pop);
        end
        if (push) r_q[r_wp] <= n_req;
    end

endmodule

>>> rtl/cpaf_back.sv
`timescale 1ns / 1ps
module cpaf_back #(
    parameter int PORT_ENTRIES = cpaf_pkg::PORT_ENTRIES_DEF,
    parameter int V4_RULES     = cpaf_pkg::V4_RULES_DEF,
    parameter int V6_RULES     = cpaf_pkg::V6_RULES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    output logic           o_q_ready,
    input  cpaf_pkg::t_req i_q_req,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_allowed,
    output logic [3:0]     o_status
);
    import cpaf_pkg::*;

    localparam int PI_W  = (PORT_ENTRIES > 1) ? $clog2(PORT_ENTRIES) : 1;
    localparam int V4I_W = (V4_RULES > 1) ? $clog2(V4_RULES) : 1;
    localparam int V6I_W = (V6_RULES > 1) ? $clog2(V6_RULES) : 1;

    logic [15:0]  r_port_tab [PORT_ENTRIES];
    logic [PORT_ENTRIES-1:0] r_port_vld;
    logic [31:0]  r_v4_net  [V4_RULES];
    logic [31:0]  r_v4_mask [V4_RULES];
    logic [V4_RULES-1:0] r_v4_vld;
    logic [63:0]  r_v6_hi   [V6_RULES];
    logic [63:0]  r_v6_lo   [V6_RULES];
    logic [7:0]   r_v6_pfx  [V6_RULES];
    logic [V6_RULES-1:0] r_v6_vld;

    // stage 1: registered per-entry compare results
    logic          r_s1_vld;
    t_req          r_s1_req;
    logic [PORT_ENTRIES-1:0] r_port_hit;
    logic [V4_RULES-1:0]     r_v4_hit;
    logic [V6_RULES-1:0]     r_v6_hit;

    logic          r_out_vld;
    logic          r_out_allowed;
    t_status       r_out_status;

    logic          s1_take, s1_done;
    logic          idx_ok;
    t_status       n_status;
    logic [31:0]   v4_m;
    logic [63:0]   mh, ml;
    logic [PI_W-1:0]  port_wi;
    logic [V4I_W-1:0] v4_wi;
    logic [V6I_W-1:0] v6_wi;

    assign s1_done   = r_s1_vld && (!r_out_vld || i_ready);
    // take a new request only into an empty stage so table writes land first
    assign o_q_ready = !r_s1_vld;
    assign s1_take   = i_q_valid && o_q_ready;

    always_comb begin
        mh   = mask64(r_s1_req.prefix);
        v4_m = mh[63:32];
        ml   = (r_s1_req.prefix > 8'd64) ? mask64(r_s1_req.prefix - 8'd64) : 64'd0;
        port_wi = PI_W'(r_s1_req.index);
        v4_wi   = V4I_W'(r_s1_req.index);
        v6_wi   = V6I_W'(r_s1_req.index);
        idx_ok = 1'b0;
        unique case (r_s1_req.op)
            OP_WR_PORT: idx_ok = 32'(r_s1_req.index) < PORT_ENTRIES;
            OP_WR_V4:   idx_ok = 32'(r_s1_req.index) < V4_RULES;
            OP_WR_V6:   idx_ok = 32'(r_s1_req.index) < V6_RULES;
            default:    idx_ok = 1'b0;
        endcase
        n_status = r_s1_req.status;
        unique case (r_s1_req.op)
            OP_WR_PORT, OP_WR_V4, OP_WR_V6:
                n_status = idx_ok ? ST_WRITE_OK : ST_WRITE_REJECT;
            OP_CLEAR: n_status = ST_WRITE_OK;
            OP_CHECK_V4, OP_CHECK_V6: begin
                if (r_port_vld == '0)          n_status = ST_NO_PORTS;
                else if (r_port_hit == '0)     n_status = ST_PORT_UNLISTED;
                else if (r_s1_req.op == OP_CHECK_V4)
                    n_status = (r_v4_vld == '0) ? ST_NO_V4 :
                               (r_v4_hit != '0) ? ST_ALLOWED : ST_NO_MATCH;
                else
                    n_status = (r_v6_vld == '0) ? ST_NO_V6 :
                               (r_v6_hit != '0) ? ST_ALLOWED : ST_NO_MATCH;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_port_vld <= '0;
            r_v4_vld   <= '0;
            r_v6_vld   <= '0;
        end else begin
            if (s1_take)      r_s1_vld <= 1'b1;
            else if (s1_done) r_s1_vld <= 1'b0;
            if (s1_done)          r_out_vld <= 1'b1;
            else if (i_ready)     r_out_vld <= 1'b0;
            if (s1_done) begin
                if (r_s1_req.op == OP_CLEAR) begin
                    r_port_vld <= '0;
                    r_v4_vld   <= '0;
                    r_v6_vld   <= '0;
                end
                if (idx_ok && r_s1_req.op == OP_WR_PORT)
                    r_port_vld[port_wi] <= 1'b1;
                if (idx_ok && r_s1_req.op == OP_WR_V4)
                    r_v4_vld[v4_wi] <= 1'b1;
                if (idx_ok && r_s1_req.op == OP_WR_V6)
                    r_v6_vld[v6_wi] <= 1'b1;
            end
        end
        if (s1_done && idx_ok) begin
            if (r_s1_req.op == OP_WR_PORT)
                r_port_tab[port_wi] <= r_s1_req.port;
            if (r_s1_req.op == OP_WR_V4) begin
                r_v4_mask[v4_wi] <= v4_m;
                r_v4_net[v4_wi]  <= r_s1_req.addr_low[31:0] & v4_m;
            end
            if (r_s1_req.op == OP_WR_V6) begin
                r_v6_pfx[v6_wi] <= r_s1_req.prefix;
                r_v6_hi[v6_wi]  <= r_s1_req.addr_high & mh;
                r_v6_lo[v6_wi]  <= r_s1_req.addr_low & ml;
            end
        end
        if (s1_take) begin
            r_s1_req <= i_q_req;
            for (int i = 0; i < PORT_ENTRIES; i++)
                r_port_hit[i] <= r_port_vld[i] && (r_port_tab[i] == i_q_req.port);
            for (int i = 0; i < V4_RULES; i++)
                r_v4_hit[i] <= r_v4_vld[i] &&
                    ((i_q_req.addr_low[31:0] & r_v4_mask[i]) == r_v4_net[i]);
            for (int i = 0; i < V6_RULES; i++)
                r_v6_hit[i] <= r_v6_vld[i] &&
                    ((i_q_req.addr_high & mask64(r_v6_pfx[i])) == r_v6_hi[i]) &&
                    ((i_q_req.addr_low & ((r_v6_pfx[i] > 8'd64) ?
                        mask64(r_v6_pfx[i] - 8'd64) : 64'd0)) == r_v6_lo[i]);
        end
        if (s1_done) begin
            r_out_status  <= n_status;
            r_out_allowed <= (n_status == ST_ALLOWED);
        end
    end

    assign o_valid   = r_out_vld;
    assign o_allowed = r_out_allowed;
    assign o_status  = r_out_status;

endmodule

>>> rtl/cidr_port_access_filter_unit.sv
`timescale 1ns / 1ps
// Access filter for connection targets.
// Input channel (i_valid/o_ready) carries one request: a check of a parsed
// address and port, a port table or prefix rule write, or a clear of all
// tables. Output channel (o_valid/i_ready) returns one result per request:
// allowed flag plus status code, in request order.
// APB registers: 0x0 listener port (always denied, 0 = unset), 0x4 IPv6
// enable. Write them only while no request is in flight.
// A request passes from acceptance through the queue behind the classifying
// front end, then the compare stage, which compares all table entries in
// parallel before the output register loads. The compare stage takes a
// request only when it is empty, so a table write lands before the next
// lookup and a new request waits until the last one has left it. When i_ready is
// low the output register holds its result, the compare stage and the
// two-entry queue fill, and o_ready drops once the queue is full.
// Reset empties all tables (valid bits cleared) and the registers to 0;
// table contents themselves are not cleared.
module cidr_port_access_filter_unit #(
    parameter int PORT_ENTRIES = cpaf_pkg::PORT_ENTRIES_DEF,
    parameter int V4_RULES     = cpaf_pkg::V4_RULES_DEF,
    parameter int V6_RULES     = cpaf_pkg::V6_RULES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_action,
    input  logic [1:0]  i_address_kind,
    input  logic [63:0] i_address_high,
    input  logic [63:0] i_address_low,
    input  logic [15:0] i_port_number,
    input  logic [3:0]  i_entry_index,
    input  logic [7:0]  i_prefix_length,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_allowed,
    output logic [3:0]  o_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cpaf_pkg::*;

    logic [15:0] r_listener;
    logic        r_v6_en;
    logic        q_valid, q_ready;
    t_req        q_req;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_listener <= '0;
            r_v6_en    <= 1'b0;
        end else if (psel && penable && pwrite) begin
            if (paddr[1:0] == 2'b00 && paddr[2] == REG_LISTENER) r_listener <= pwdata[15:0];
            if (paddr[1:0] == 2'b00 && paddr[2] == REG_IPV6_EN)  r_v6_en    <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_LISTENER) prdata = {16'd0, r_listener};
        else                          prdata = {31'd0, r_v6_en};
    end

    cpaf_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_action, .i_address_kind, .i_address_high, .i_address_low,
        .i_port_number, .i_entry_index, .i_prefix_length,
        .i_listener_port(r_listener), .i_ipv6_enable(r_v6_en),
        .o_q_valid(q_valid), .i_q_ready(q_ready), .o_q_req(q_req)
    );

    cpaf_back #(
        .PORT_ENTRIES(PORT_ENTRIES), .V4_RULES(V4_RULES), .V6_RULES(V6_RULES)
    ) u_back (
        .i_clk, .i_rst_n, .i_q_valid(q_valid), .o_q_ready(q_ready), .i_q_req(q_req),
        .o_valid, .i_ready, .o_allowed, .o_status
    );

    a_allowed_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_allowed |-> o_status == ST_ALLOWED) else $error("allowed mismatch");
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status)) else $error("output dropped");
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= ST_WRITE_REJECT) else $error("bad status");

endmodule
